FILE: hw/rtl/pva_pkg.sv
`timescale 1ns / 1ps

package pva_pkg;

    // Request codes carried on s_tuser
    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_OPEN    = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_AGE     = 3'd3;
    localparam logic [2:0] REQ_SET     = 3'd4;

    // Voice kinds
    localparam logic [1:0] KIND_PLAIN = 2'd1;
    localparam logic [1:0] KIND_SEQ   = 2'd2;

    // Stop actions reported for a stolen voice
    localparam logic [1:0] STOP_NONE        = 2'd0;
    localparam logic [1:0] STOP_NOTE_OFF    = 2'd1;
    localparam logic [1:0] STOP_ENV_RELEASE = 2'd2;

    // Priority stored by open fixed, and start value of the minimum search
    localparam logic signed [7:0] PRIO_TOP = 8'sh7F;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;

    // Per-voice control fields held in the table next to the age
    typedef struct packed {
        logic              busy;
        logic              prot;
        logic [1:0]        kind;
        logic signed [7:0] prio;
    } voice_ctl_t;

    // Operation of the shared compare unit
    typedef enum logic [1:0] {
        STEP_MIN = 2'd0,
        STEP_OLD = 2'd1,
        STEP_AGE = 2'd2
    } step_mode_t;

endpackage

FILE: hw/rtl/priority_voice_allocator.sv
`timescale 1ns / 1ps

// Voice table with priority-based stealing. One request is taken at a time
// (s_tready is high only while idle) and each gives exactly one result on m_.
// The voice table lives in one single-port-write RAM with registered read, so
// every lookup is a scan that streams one voice per cycle through a shared
// compare unit. A group allocate stops at the first free voice it finds,
// otherwise it runs a free scan, a minimum-priority scan, an oldest-voice
// scan and a steal decision. An age tick sweeps the whole table; open,
// release and set each scan a single voice.
// A result waits in the output register while the next request is accepted.
// Reset clears the table at once through per-voice valid flags; no clearing
// pass is needed.
module priority_voice_allocator #(
    parameter int NUM_VOICES = 64,
    parameter int AGE_BITS   = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [5:0] group_start, [11:6] group_last, [19:12] req_prio, [20] allow_equal,
    // [21] want_seq_kind, [27:22] voice_index, [29:28] open_kind, [30] protect
    input  logic [pva_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [2:0] req_type
    input  logic [pva_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] granted, [6:1] granted_voice, [8:7] stop_action
    output logic [pva_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(NUM_VOICES);
    localparam int W  = $bits(pva_pkg::voice_ctl_t) + AGE_BITS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FREE   = 8'b0000_0010,
        S_MIN    = 8'b0000_0100,
        S_OLD    = 8'b0000_1000,
        S_STEAL  = 8'b0001_0000,
        S_SINGLE = 8'b0010_0000,
        S_AGE    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Latched request
    logic [2:0]        op_reg, op_next;
    logic signed [7:0] prio_reg, prio_next;
    logic              allow_eq_reg, allow_eq_next;
    logic              want_seq_reg, want_seq_next;
    logic [1:0]        okind_reg, okind_next;
    logic              prot_reg, prot_next;
    logic [AW-1:0]     grp_start_reg, grp_start_next;

    // Scan engine
    logic [AW-1:0]     sc_addr_reg, sc_addr_next;
    logic [AW-1:0]     sc_end_reg, sc_end_next;
    logic              sc_issue_reg, sc_issue_next;
    logic              sc_dv_reg, sc_dv_next;
    logic [AW-1:0]     sc_didx_reg, sc_didx_next;
    logic              sc_dlast_reg, sc_dlast_next;

    // Search accumulators
    logic signed [7:0] minp_reg, minp_next;
    logic [AGE_BITS-1:0] best_reg, best_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     victim_reg, victim_next;
    logic [1:0]        vkind_reg, vkind_next;
    logic              vprot_reg, vprot_next;

    // Pending result and output register
    logic              res_granted_reg, res_granted_next;
    logic [5:0]        res_voice_reg, res_voice_next;
    logic [1:0]        res_stop_reg, res_stop_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_granted_reg, m_granted_next;
    logic [5:0]        m_voice_reg, m_voice_next;
    logic [1:0]        m_stop_reg, m_stop_next;

    // Table storage and valid flags
    logic [NUM_VOICES-1:0] valid_reg;
    logic                  vld_q_reg;
    logic [W-1:0]          ram_q;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    pva_pkg::voice_ctl_t   wr_ctl;
    logic [AGE_BITS-1:0]   wr_age;
    pva_pkg::voice_ctl_t   rd_ctl;
    logic [AGE_BITS-1:0]   rd_age;

    // Compare unit
    pva_pkg::step_mode_t   step_mode;
    logic                  step_hit;
    logic [AGE_BITS-1:0]   step_age_inc;

    // Request decode
    logic [5:0]        in_start;
    logic [5:0]        in_last;
    logic [5:0]        in_index;
    logic [6:0]        end_sum;
    logic [AW-1:0]     grp_end;
    logic              start_ok;
    logic              index_ok;
    logic [1:0]        nkind;
    logic              steal_ok;

    pva_ram #(
        .WIDTH (W),
        .DEPTH (NUM_VOICES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({wr_ctl, wr_age}),
        .rd_addr (sc_addr_reg),
        .rd_data (ram_q)
    );

    pva_step #(
        .AGE_BITS (AGE_BITS)
    ) u_step (
        .mode       (step_mode),
        .ctl        (rd_ctl),
        .age        (rd_age),
        .prio_floor (minp_reg),
        .best_age   (best_reg),
        .hit        (step_hit),
        .age_inc    (step_age_inc)
    );

    // A voice never written reads as the reset value
    assign rd_ctl = vld_q_reg ? pva_pkg::voice_ctl_t'(ram_q[W-1:AGE_BITS]) : '0;
    assign rd_age = vld_q_reg ? ram_q[AGE_BITS-1:0] : '0;

    assign in_start = s_tdata[5:0];
    assign in_last  = s_tdata[11:6];
    assign in_index = s_tdata[27:22];
    assign end_sum  = {1'b0, in_start} + {1'b0, in_last};
    assign start_ok = (32'(in_start) < NUM_VOICES);
    assign index_ok = (32'(in_index) < NUM_VOICES);
    assign grp_end  = (32'(end_sum) > NUM_VOICES - 1) ? AW'(NUM_VOICES - 1) : AW'(end_sum);

    assign nkind    = want_seq_reg ? pva_pkg::KIND_SEQ : pva_pkg::KIND_PLAIN;
    assign steal_ok = ((minp_reg < prio_reg) || ((minp_reg == prio_reg) && allow_eq_reg))
                      && found_reg && (vkind_reg == nkind) && !vprot_reg;

    assign step_mode = (state_reg == S_MIN) ? pva_pkg::STEP_MIN :
                       (state_reg == S_OLD) ? pva_pkg::STEP_OLD : pva_pkg::STEP_AGE;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_stop_reg, m_voice_reg, m_granted_reg};

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        prio_next        = prio_reg;
        allow_eq_next    = allow_eq_reg;
        want_seq_next    = want_seq_reg;
        okind_next       = okind_reg;
        prot_next        = prot_reg;
        grp_start_next   = grp_start_reg;
        sc_addr_next     = sc_addr_reg;
        sc_end_next      = sc_end_reg;
        sc_issue_next    = sc_issue_reg;
        minp_next        = minp_reg;
        best_next        = best_reg;
        found_next       = found_reg;
        victim_next      = victim_reg;
        vkind_next       = vkind_reg;
        vprot_next       = vprot_reg;
        res_granted_next = res_granted_reg;
        res_voice_next   = res_voice_reg;
        res_stop_next    = res_stop_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_granted_next   = m_granted_reg;
        m_voice_next     = m_voice_reg;
        m_stop_next      = m_stop_reg;
        wr_en            = 1'b0;
        wr_addr          = sc_didx_reg;
        wr_ctl           = rd_ctl;
        wr_age           = rd_age;

        // Advance the scan: one read issued per cycle, its data arriving in the next cycle
        sc_dv_next    = sc_issue_reg;
        sc_didx_next  = sc_addr_reg;
        sc_dlast_next = (sc_addr_reg == sc_end_reg);
        if (sc_issue_reg) begin
            if (sc_addr_reg == sc_end_reg) begin
                sc_issue_next = 1'b0;
            end else begin
                sc_addr_next = sc_addr_reg + AW'(1);
            end
        end

        // Drop the output once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next          = s_tuser;
                    prio_next        = s_tdata[19:12];
                    allow_eq_next    = s_tdata[20];
                    want_seq_next    = s_tdata[21];
                    okind_next       = s_tdata[29:28];
                    prot_next        = s_tdata[30];
                    grp_start_next   = AW'(in_start);
                    res_granted_next = 1'b0;
                    res_voice_next   = '0;
                    res_stop_next    = pva_pkg::STOP_NONE;
                    sc_dv_next       = 1'b0;
                    state_next       = S_DONE;
                    unique case (s_tuser)
                        pva_pkg::REQ_ALLOC: begin
                            if (start_ok) begin
                                sc_addr_next  = AW'(in_start);
                                sc_end_next   = grp_end;
                                sc_issue_next = 1'b1;
                                state_next    = S_FREE;
                            end
                        end
                        pva_pkg::REQ_OPEN, pva_pkg::REQ_RELEASE, pva_pkg::REQ_SET: begin
                            if (index_ok) begin
                                sc_addr_next  = AW'(in_index);
                                sc_end_next   = AW'(in_index);
                                sc_issue_next = 1'b1;
                                state_next    = S_SINGLE;
                            end
                        end
                        pva_pkg::REQ_AGE: begin
                            sc_addr_next  = '0;
                            sc_end_next   = AW'(NUM_VOICES - 1);
                            sc_issue_next = 1'b1;
                            state_next    = S_AGE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_FREE: begin
                if (sc_dv_reg) begin
                    if (!rd_ctl.busy) begin
                        // Take the first free voice
                        wr_en            = 1'b1;
                        wr_ctl           = '{busy: 1'b1, prot: 1'b0, kind: nkind,
                                             prio: prio_reg};
                        wr_age           = '0;
                        res_granted_next = 1'b1;
                        res_voice_next   = 6'(sc_didx_reg);
                        sc_issue_next    = 1'b0;
                        sc_dv_next       = 1'b0;
                        state_next       = S_DONE;
                    end else if (sc_dlast_reg) begin
                        sc_addr_next  = grp_start_reg;
                        sc_issue_next = 1'b1;
                        sc_dv_next    = 1'b0;
                        minp_next     = pva_pkg::PRIO_TOP;
                        state_next    = S_MIN;
                    end
                end
            end

            S_MIN: begin
                if (sc_dv_reg) begin
                    if (step_hit) begin
                        minp_next = rd_ctl.prio;
                    end
                    if (sc_dlast_reg) begin
                        sc_addr_next  = grp_start_reg;
                        sc_issue_next = 1'b1;
                        sc_dv_next    = 1'b0;
                        best_next     = '0;
                        found_next    = 1'b0;
                        state_next    = S_OLD;
                    end
                end
            end

            S_OLD: begin
                if (sc_dv_reg) begin
                    // Hold the oldest voice at minimum priority, later index on ties
                    if (step_hit) begin
                        best_next   = rd_age;
                        victim_next = sc_didx_reg;
                        vkind_next  = rd_ctl.kind;
                        vprot_next  = rd_ctl.prot;
                        found_next  = 1'b1;
                    end
                    if (sc_dlast_reg) begin
                        state_next = S_STEAL;
                    end
                end
            end

            S_STEAL: begin
                if (steal_ok) begin
                    wr_en            = 1'b1;
                    wr_addr          = victim_reg;
                    wr_ctl           = '{busy: 1'b1, prot: 1'b0, kind: nkind,
                                         prio: prio_reg};
                    wr_age           = '0;
                    res_granted_next = 1'b1;
                    res_voice_next   = 6'(victim_reg);
                    res_stop_next    = (vkind_reg == pva_pkg::KIND_SEQ) ?
                                       pva_pkg::STOP_NOTE_OFF : pva_pkg::STOP_ENV_RELEASE;
                end
                state_next = S_DONE;
            end

            S_SINGLE: begin
                if (sc_dv_reg) begin
                    state_next = S_DONE;
                    unique case (op_reg)
                        pva_pkg::REQ_OPEN: begin
                            if (!rd_ctl.busy) begin
                                wr_en            = 1'b1;
                                wr_ctl           = '{busy: 1'b1, prot: 1'b0, kind: okind_reg,
                                                     prio: pva_pkg::PRIO_TOP};
                                wr_age           = '0;
                                res_granted_next = 1'b1;
                                res_voice_next   = 6'(sc_didx_reg);
                            end
                        end
                        pva_pkg::REQ_RELEASE: begin
                            wr_en            = 1'b1;
                            wr_ctl.busy      = 1'b0;
                            wr_ctl.prot      = 1'b0;
                            res_granted_next = 1'b1;
                            res_voice_next   = 6'(sc_didx_reg);
                        end
                        pva_pkg::REQ_SET: begin
                            wr_en            = 1'b1;
                            wr_ctl.prio      = prio_reg;
                            wr_ctl.prot      = prot_reg;
                            res_granted_next = 1'b1;
                            res_voice_next   = 6'(sc_didx_reg);
                        end
                        default: begin
                            res_granted_next = 1'b0;
                        end
                    endcase
                end
            end

            S_AGE: begin
                if (sc_dv_reg) begin
                    // Bump the age of busy voices, saturating
                    if (step_hit) begin
                        wr_en  = 1'b1;
                        wr_age = step_age_inc;
                    end
                    if (sc_dlast_reg) begin
                        res_granted_next = 1'b1;
                        state_next       = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_voice_next   = res_voice_reg;
                    m_stop_next    = res_stop_reg;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sc_issue_reg <= 1'b0;
            sc_dv_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            sc_issue_reg <= sc_issue_next;
            sc_dv_reg    <= sc_dv_next;
            m_tvalid_reg <= m_tvalid_next;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        prio_reg        <= prio_next;
        allow_eq_reg    <= allow_eq_next;
        want_seq_reg    <= want_seq_next;
        okind_reg       <= okind_next;
        prot_reg        <= prot_next;
        grp_start_reg   <= grp_start_next;
        sc_addr_reg     <= sc_addr_next;
        sc_end_reg      <= sc_end_next;
        sc_didx_reg     <= sc_didx_next;
        sc_dlast_reg    <= sc_dlast_next;
        vld_q_reg       <= valid_reg[sc_addr_reg];
        minp_reg        <= minp_next;
        best_reg        <= best_next;
        found_reg       <= found_next;
        victim_reg      <= victim_next;
        vkind_reg       <= vkind_next;
        vprot_reg       <= vprot_next;
        res_granted_reg <= res_granted_next;
        res_voice_reg   <= res_voice_next;
        res_stop_reg    <= res_stop_next;
        m_granted_reg   <= m_granted_next;
        m_voice_reg     <= m_voice_next;
        m_stop_reg      <= m_stop_next;
    end

endmodule

FILE: hw/rtl/pva_ram.sv
`timescale 1ns / 1ps

module pva_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/pva_step.sv
`timescale 1ns / 1ps

module pva_step #(
    parameter int AGE_BITS = 16
) (
    input  pva_pkg::step_mode_t  mode,
    input  pva_pkg::voice_ctl_t  ctl,
    input  logic [AGE_BITS-1:0]  age,
    input  logic signed [7:0]    prio_floor,
    input  logic [AGE_BITS-1:0]  best_age,
    output logic                 hit,
    output logic [AGE_BITS-1:0]  age_inc
);

    localparam int CW = ((AGE_BITS > 8) ? AGE_BITS : 8) + 1;

    logic signed [CW-1:0] cmp_a;
    logic signed [CW-1:0] cmp_b;
    logic                 cmp_le;

    // Route operands into the one magnitude comparator
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (mode)
            pva_pkg::STEP_MIN: begin
                cmp_a = CW'(ctl.prio);
                cmp_b = CW'(prio_floor);
            end
            pva_pkg::STEP_OLD: begin
                cmp_a = CW'(best_age);
                cmp_b = CW'(age);
            end
            pva_pkg::STEP_AGE: begin
                cmp_a = CW'({AGE_BITS{1'b1}});
                cmp_b = CW'(age);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_le  = (cmp_a <= cmp_b);
    assign age_inc = age + AGE_BITS'(1);

    // Interpret the compare for the current scan
    always_comb begin
        unique case (mode)
            pva_pkg::STEP_MIN: hit = cmp_le;
            pva_pkg::STEP_OLD: hit = (ctl.prio == prio_floor) && cmp_le;
            pva_pkg::STEP_AGE: hit = ctl.busy && !cmp_le;
            default:           hit = 1'b0;
        endcase
    end

endmodule

FILE: hw/rtl/pva_checker.sv
`timescale 1ns / 1ps

module pva_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pva_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // No result is shown right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One request at a time: an accepted request closes the input
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // A refused request carries no voice and no stop action
    a_refused_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("refused request with payload");

    // Stop action is a defined code, and only on a grant
    a_stop_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8:7] != pva_pkg::STOP_NONE
        |-> m_tdata[0] && m_tdata[8:7] != 2'd3)
        else $error("bad stop action");

endmodule

bind priority_voice_allocator pva_checker u_pva_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/tb_priority_voice_allocator.sv
`timescale 1ns / 1ps

module tb_priority_voice_allocator;
    import pva_pkg::*;

    localparam int NV    = 64;
    localparam int AGE_W = 16;

    // Highest code the 3-bit request type field can carry
    localparam logic [2:0] REQ_LAST_CODE = 3'd7;

    // Request payload, packed so that group_start sits in the lowest bits
    typedef struct packed {
        logic       prot;
        logic [1:0] open_kind;
        logic [5:0] voice;
        logic       want_seq;
        logic       allow_eq;
        logic [7:0] prio;
        logic [5:0] last;
        logic [5:0] start;
    } voice_req_t;

    typedef struct packed {
        logic       granted;
        logic [5:0] voice;
        logic [1:0] stop;
    } grant_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Shadow copy of the voice table
    logic                   v_busy [NV];
    logic                   v_prot [NV];
    logic [1:0]             v_kind [NV];
    logic signed [7:0]      v_prio [NV];
    logic [AGE_W-1:0]       v_age  [NV];

    grant_t pending_grants[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int free_grants    = 0;
    int steals         = 0;
    int refused_allocs = 0;
    int age_ticks      = 0;

    priority_voice_allocator #(
        .NUM_VOICES(NV),
        .AGE_BITS  (AGE_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result channel at the rate of the current phase
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic claim_voice(input int unsigned v, input logic [1:0] kind,
                               input logic signed [7:0] prio);
        v_busy[v] = 1'b1;
        v_prot[v] = 1'b0;
        v_kind[v] = kind;
        v_prio[v] = prio;
        v_age[v]  = '0;
    endtask

    // Apply one request to the shadow table and return the grant it yields
    task automatic predict_voice_request(input logic [2:0] code, input voice_req_t r,
                                         output grant_t g);
        int unsigned       i;
        int unsigned       hi;
        int unsigned       victim;
        logic signed [7:0] rp;
        logic signed [7:0] minp;
        logic [AGE_W-1:0]  oldest;
        logic              found;
        logic [1:0]        nkind;
        g      = '0;
        rp     = $signed(r.prio);
        victim = 0;
        found  = 1'b0;
        oldest = '0;
        case (code)
            REQ_ALLOC: begin
                nkind = r.want_seq ? KIND_SEQ : KIND_PLAIN;
                hi = 32'(r.start) + 32'(r.last);
                if (hi > NV - 1) hi = NV - 1;
                // take the first free voice of the group
                for (i = 32'(r.start); i <= hi && !g.granted; i++) begin
                    if (!v_busy[i]) begin
                        claim_voice(i, nkind, rp);
                        g.granted = 1'b1;
                        g.voice   = i[5:0];
                        free_grants++;
                    end
                end
                if (!g.granted) begin
                    minp = PRIO_TOP;
                    for (i = 32'(r.start); i <= hi; i++)
                        if (v_prio[i] <= minp) minp = v_prio[i];
                    if (minp < rp || (minp == rp && r.allow_eq)) begin
                        // oldest voice at the lowest priority, later index on ties
                        for (i = 32'(r.start); i <= hi; i++) begin
                            if (v_prio[i] == minp && oldest <= v_age[i]) begin
                                oldest = v_age[i];
                                victim = i;
                                found  = 1'b1;
                            end
                        end
                        if (found && v_kind[victim] == nkind && !v_prot[victim]) begin
                            g.stop = (v_kind[victim] == KIND_SEQ) ? STOP_NOTE_OFF
                                                                  : STOP_ENV_RELEASE;
                            claim_voice(victim, nkind, rp);
                            g.granted = 1'b1;
                            g.voice   = victim[5:0];
                            steals++;
                        end
                    end
                    if (!g.granted) refused_allocs++;
                end
            end
            REQ_OPEN: begin
                if (!v_busy[r.voice]) begin
                    claim_voice(32'(r.voice), r.open_kind, PRIO_TOP);
                    g.granted = 1'b1;
                    g.voice   = r.voice;
                end
            end
            REQ_RELEASE: begin
                v_busy[r.voice] = 1'b0;
                v_prot[r.voice] = 1'b0;
                g.granted = 1'b1;
                g.voice   = r.voice;
            end
            REQ_AGE: begin
                for (i = 0; i < NV; i++)
                    if (v_busy[i] && v_age[i] != {AGE_W{1'b1}})
                        v_age[i] = v_age[i] + AGE_W'(1);
                g.granted = 1'b1;
                age_ticks++;
            end
            REQ_SET: begin
                v_prio[r.voice] = rp;
                v_prot[r.voice] = r.prot;
                g.granted = 1'b1;
                g.voice   = r.voice;
            end
            default: ;
        endcase
    endtask

    // Drive one request from a falling edge and hold it until accepted
    task automatic send_request(input logic [2:0] code, input voice_req_t r);
        grant_t g;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {1'b0, r};
        do @(posedge aclk); while (!s_tready);
        predict_voice_request(code, r, g);
        pending_grants.push_back(g);
        requests_sent++;
        @(negedge aclk);
    endtask

    function automatic voice_req_t make_req(input logic [5:0] start, input logic [5:0] last,
                                            input logic [7:0] prio, input logic allow_eq,
                                            input logic want_seq, input logic [5:0] voice,
                                            input logic [1:0] kind, input logic prot);
        voice_req_t r;
        r.start     = start;
        r.last      = last;
        r.prio      = prio;
        r.allow_eq  = allow_eq;
        r.want_seq  = want_seq;
        r.voice     = voice;
        r.open_kind = kind;
        r.prot      = prot;
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0d got %0d", results_seen, name, want, got);
        end
    endtask

    // Compare each accepted result with the oldest pending grant
    always @(posedge aclk) begin : check_results
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result 0x%h with no request pending", m_tdata);
            end else begin
                want = pending_grants.pop_front();
                report_field("granted", int'(want.granted), int'(m_tdata[0]));
                report_field("granted_voice", int'(want.voice), int'(m_tdata[6:1]));
                report_field("stop_action", int'(want.stop), int'(m_tdata[8:7]));
            end
        end
    end

    // Walk through free grants, steals of both kinds and every refusal
    task automatic test_directed();
        logic [31:0] tmp;
        int          c;
        send_request(REQ_ALLOC,   make_req(6'd0, 6'd1, 8'd5, 1'b0, 1'b0, 6'd0, 2'd1, 1'b0));
        send_request(REQ_ALLOC,   make_req(6'd0, 6'd1, 8'd5, 1'b0, 1'b1, 6'd0, 2'd1, 1'b0));
        send_request(REQ_AGE,     make_req(6'd0, 6'd0, 8'd0, 1'b0, 1'b0, 6'd0, 2'd1, 1'b0));
        // equal priority without allow_equal, then with it
        send_request(REQ_ALLOC,   make_req(6'd0, 6'd1, 8'd5, 1'b0, 1'b1, 6'd0, 2'd1, 1'b0));
        send_request(REQ_ALLOC,   make_req(6'd0, 6'd1, 8'd5, 1'b1, 1'b1, 6'd0, 2'd1, 1'b0));
        // wrong kind for the oldest victim
        send_request(REQ_ALLOC,   make_req(6'd0, 6'd1, 8'd5, 1'b1, 1'b1, 6'd0, 2'd1, 1'b0));
        send_request(REQ_ALLOC,   make_req(6'd0, 6'd1, 8'd6, 1'b0, 1'b0, 6'd0, 2'd1, 1'b0));
        // protected victim
        send_request(REQ_SET,     make_req(6'd0, 6'd0, 8'h80, 1'b0, 1'b0, 6'd0, 2'd1, 1'b1));
        send_request(REQ_ALLOC,   make_req(6'd0, 6'd1, 8'h7F, 1'b1, 1'b0, 6'd0, 2'd1, 1'b0));
        send_request(REQ_ALLOC,   make_req(6'd0, 6'd0, 8'h80, 1'b1, 1'b0, 6'd0, 2'd1, 1'b0));
        send_request(REQ_RELEASE, make_req(6'd0, 6'd0, 8'd0, 1'b0, 1'b0, 6'd0, 2'd1, 1'b0));
        // open on a free voice, then on a busy one
        send_request(REQ_OPEN,    make_req(6'd0, 6'd0, 8'd0, 1'b0, 1'b0, 6'd0, 2'd3, 1'b0));
        send_request(REQ_OPEN,    make_req(6'd0, 6'd0, 8'd0, 1'b0, 1'b0, 6'd0, 2'd1, 1'b0));
        send_request(REQ_OPEN,    make_req(6'd0, 6'd0, 8'd0, 1'b0, 1'b0, 6'd63, 2'd2, 1'b0));
        // groups running past the table end
        send_request(REQ_ALLOC,   make_req(6'd63, 6'd63, 8'd0, 1'b0, 1'b0, 6'd0, 2'd1, 1'b0));
        send_request(REQ_ALLOC,   make_req(6'd60, 6'd63, 8'hFF, 1'b0, 1'b0, 6'd0, 2'd1, 1'b0));
        send_request(REQ_SET,     make_req(6'd0, 6'd0, 8'h80, 1'b0, 1'b0, 6'd63, 2'd1, 1'b0));
        send_request(REQ_ALLOC,   make_req(6'd63, 6'd0, 8'h7F, 1'b0, 1'b1, 6'd0, 2'd1, 1'b0));
        send_request(REQ_RELEASE, make_req(6'd0, 6'd0, 8'd0, 1'b0, 1'b0, 6'd63, 2'd1, 1'b0));
        // unknown request types with random payload
        for (c = int'(REQ_SET) + 1; c <= int'(REQ_LAST_CODE); c++) begin
            tmp = $urandom;
            send_request(c[2:0], tmp[30:0]);
        end
        send_request(REQ_AGE,     make_req(6'd0, 6'd0, 8'd0, 1'b0, 1'b0, 6'd0, 2'd1, 1'b0));
        send_request(REQ_ALLOC,   make_req(6'd63, 6'd63, 8'h7F, 1'b1, 1'b1, 6'd63, 2'd3, 1'b1));
    endtask

    // Mixed traffic weighted toward allocates so that groups fill and steal
    task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
        voice_req_t  r;
        logic [31:0] tmp;
        logic [2:0]  code;
        int          pick;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (n) begin
            tmp  = $urandom;
            r    = tmp[30:0];
            pick = $urandom_range(99);
            if (pick < 48)      code = REQ_ALLOC;
            else if (pick < 58) code = REQ_OPEN;
            else if (pick < 70) code = REQ_RELEASE;
            else if (pick < 80) code = REQ_AGE;
            else                code = REQ_SET;
            // mostly small groups on aligned bases
            if ($urandom_range(99) < 80) r.last = 6'($urandom_range(7));
            if ($urandom_range(99) < 60) begin
                tmp = $urandom;
                r.start = {tmp[2:0], 3'b000};
            end
            // keep priorities in a narrow band most of the time to hit ties
            if ($urandom_range(99) < 70) begin
                tmp = $urandom_range(6);
                r.prio = tmp[7:0] - 8'd3;
            end
            r.open_kind = 2'($urandom_range(3, 1));
            r.prot = ($urandom_range(99) < 30);
            send_request(code, r);
        end
    endtask

    initial begin : stimulus
        int i;
        for (i = 0; i < NV; i++) begin
            v_busy[i] = 1'b0;
            v_prot[i] = 1'b0;
            v_kind[i] = '0;
            v_prio[i] = '0;
            v_age[i]  = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_traffic(175, 0, 0);
        test_random_traffic(175, 70, 0);
        test_random_traffic(175, 0, 70);
        test_random_traffic(175, 26, 26);
        s_tvalid <= 1'b0;

        // drain, then watch for stray results
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);

        $display("ran %0d requests (%0d results) over four traffic phases",
                 requests_sent, results_seen);
        $display("free grants %0d, steals %0d, refused allocates %0d, age ticks %0d",
                 free_grants, steals, refused_allocs, age_ticks);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("timeout with %0d results pending", pending_grants.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: priority_voice_allocator.f
hw/rtl/pva_pkg.sv
hw/rtl/pva_ram.sv
hw/rtl/pva_step.sv
hw/rtl/priority_voice_allocator.sv
hw/rtl/pva_checker.sv
verif/tb_priority_voice_allocator.sv
